// ===== rtl/ipv4p_pkg.sv =====
// shared types and constants for the ipv4 dotted address parser
`timescale 1ns / 1ps
package ipv4p_pkg;

	localparam int unsigned CharW  = 8;
	localparam int unsigned AddrW  = 32;
	localparam int unsigned CountW = 3;
	localparam int unsigned PartW  = 9;
	localparam int unsigned ValW   = 33;

	localparam logic [CharW-1:0] ChNul = 8'h00;
	localparam logic [CharW-1:0] ChDot = 8'h2e;
	localparam logic [CharW-1:0] ChSp  = 8'h20;
	localparam logic [CharW-1:0] ChTab = 8'h09;
	localparam logic [CharW-1:0] ChCr  = 8'h0d;
	localparam logic [CharW-1:0] ChD0  = 8'h30;
	localparam logic [CharW-1:0] ChD7  = 8'h37;
	localparam logic [CharW-1:0] ChD9  = 8'h39;
	localparam logic [CharW-1:0] ChLa  = 8'h61;
	localparam logic [CharW-1:0] ChLf  = 8'h66;
	localparam logic [CharW-1:0] ChUa  = 8'h41;
	localparam logic [CharW-1:0] ChUf  = 8'h46;
	localparam logic [CharW-1:0] ChLx  = 8'h78;
	localparam logic [CharW-1:0] ChUx  = 8'h58;

	typedef struct packed {
		logic       is_nul;
		logic       is_ws;
		logic       is_dot;
		logic       is_x;
		logic       is_zero;
		logic       dec_ok;
		logic       oct_ok;
		logic       hex_ok;
		logic [3:0] digit;
	} char_class_t;

	typedef struct packed {
		logic                  valid_res;
		logic [AddrW-1:0]      address;
		logic [CountW-1:0]     part_count;
	} result_t;

endpackage

// ===== rtl/ipv4p_char_class.sv =====
// character classifier: digit value and character classes of one byte
`timescale 1ns / 1ps
module ipv4p_char_class (
	input  logic [ipv4p_pkg::CharW-1:0] char_code,
	output ipv4p_pkg::char_class_t      cls
);

	logic is_dec, is_lhex, is_uhex;

	always_comb begin
		is_dec  = (char_code >= ipv4p_pkg::ChD0) && (char_code <= ipv4p_pkg::ChD9);
		is_lhex = (char_code >= ipv4p_pkg::ChLa) && (char_code <= ipv4p_pkg::ChLf);
		is_uhex = (char_code >= ipv4p_pkg::ChUa) && (char_code <= ipv4p_pkg::ChUf);
		cls.is_nul  = (char_code == ipv4p_pkg::ChNul);
		cls.is_ws   = ((char_code >= ipv4p_pkg::ChTab) && (char_code <= ipv4p_pkg::ChCr))
			|| (char_code == ipv4p_pkg::ChSp);
		cls.is_dot  = (char_code == ipv4p_pkg::ChDot);
		cls.is_x    = (char_code == ipv4p_pkg::ChLx) || (char_code == ipv4p_pkg::ChUx);
		cls.is_zero = (char_code == ipv4p_pkg::ChD0);
		cls.dec_ok  = is_dec;
		cls.oct_ok  = (char_code >= ipv4p_pkg::ChD0) && (char_code <= ipv4p_pkg::ChD7);
		cls.hex_ok  = is_dec || is_lhex || is_uhex;
		if (is_dec) begin
			cls.digit = char_code[3:0];
		end else if (is_lhex || is_uhex) begin
			cls.digit = char_code[3:0] + 4'd9;
		end else begin
			cls.digit = 4'd0;
		end
	end

endmodule

// ===== rtl/ipv4p_parse_core.sv =====
// parse state, part accumulator and address assembly
`timescale 1ns / 1ps
module ipv4p_parse_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  ipv4p_pkg::char_class_t  cls,
	output ipv4p_pkg::result_t      res
);

	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_DEC    = 3'd1;
	localparam logic [2:0] PH_ZERO   = 3'd2;
	localparam logic [2:0] PH_HEXPFX = 3'd3;
	localparam logic [2:0] PH_OCT    = 3'd4;
	localparam logic [2:0] PH_HEX    = 3'd5;
	localparam logic [2:0] PH_DONE   = 3'd6;

	localparam int unsigned SumW = ipv4p_pkg::ValW + 4;

	logic [2:0]                    phase_q, phase_d;
	logic [1:0]                    idx_q, idx_d;
	logic [ipv4p_pkg::ValW-1:0]    cur_q, cur_d;
	logic                          err_q, err_d;
	logic [ipv4p_pkg::PartW-1:0]   parts_q [3];
	logic                          part_we;
	logic [ipv4p_pkg::PartW-1:0]   part_new;

	logic                          complete;
	logic [SumW-1:0]               cur_x, prod, sum;
	logic                          sat;
	logic [ipv4p_pkg::ValW-1:0]    acc;
	logic                          ok;
	logic [ipv4p_pkg::AddrW-1:0]   val, addr;

	// accumulator: value times base plus digit, saturating above 32 bits
	always_comb begin
		cur_x = {{(SumW-ipv4p_pkg::ValW){1'b0}}, cur_q};
		unique case (phase_q)
			PH_DEC:              prod = (cur_x << 3) + (cur_x << 1);
			PH_HEXPFX, PH_HEX:   prod = cur_x << 4;
			default:             prod = cur_x << 3;
		endcase
		sum = prod + {{(SumW-4){1'b0}}, cls.digit};
		sat = (sum[SumW-1:ipv4p_pkg::AddrW] != '0);
		acc = sat ? {1'b1, {ipv4p_pkg::AddrW{1'b0}}} : sum[ipv4p_pkg::ValW-1:0];
	end

	always_comb begin
		complete = (phase_q == PH_DEC) || (phase_q == PH_ZERO)
			|| (phase_q == PH_OCT) || (phase_q == PH_HEX);
		part_new = (cur_q > ipv4p_pkg::ValW'(8'hff)) ? 9'h100 : cur_q[ipv4p_pkg::PartW-1:0];
	end

	// result for the terminating nul
	always_comb begin
		ok   = !err_q && ((phase_q == PH_DONE) || complete);
		val  = cur_q[ipv4p_pkg::AddrW-1:0];
		addr = '0;
		unique case (idx_q)
			2'd0: addr = val;
			2'd1: begin
				if ((val > 32'h00ff_ffff) || parts_q[0][8]) begin
					ok = 1'b0;
				end else begin
					addr = val | {parts_q[0][7:0], 24'h0};
				end
			end
			2'd2: begin
				if ((val > 32'h0000_ffff) || parts_q[0][8] || parts_q[1][8]) begin
					ok = 1'b0;
				end else begin
					addr = val | {parts_q[0][7:0], parts_q[1][7:0], 16'h0};
				end
			end
			default: begin
				if ((val > 32'h0000_00ff) || parts_q[0][8] || parts_q[1][8]
					|| parts_q[2][8]) begin
					ok = 1'b0;
				end else begin
					addr = val | {parts_q[0][7:0], parts_q[1][7:0], parts_q[2][7:0], 8'h0};
				end
			end
		endcase
		res.valid_res  = ok;
		res.address    = ok ? addr : '0;
		res.part_count = {1'b0, idx_q} + 3'd1;
	end

	// next state for one item
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		cur_d   = cur_q;
		err_d   = err_q;
		part_we = 1'b0;
		if (cls.is_nul) begin
			phase_d = PH_START;
			idx_d   = '0;
			cur_d   = '0;
			err_d   = 1'b0;
		end else if (!err_q && (phase_q != PH_DONE)) begin
			if (cls.is_dot || cls.is_ws) begin
				if (!complete) begin
					err_d = 1'b1;
				end else if (cls.is_ws) begin
					phase_d = PH_DONE;
				end else if (idx_q == 2'd3) begin
					err_d = 1'b1;
				end else begin
					part_we = 1'b1;
					idx_d   = idx_q + 2'd1;
					cur_d   = '0;
					phase_d = PH_START;
				end
			end else begin
				unique case (phase_q)
					PH_START: begin
						if (cls.is_zero) begin
							phase_d = PH_ZERO;
						end else if (cls.dec_ok) begin
							cur_d   = {{(ipv4p_pkg::ValW-4){1'b0}}, cls.digit};
							phase_d = PH_DEC;
						end else begin
							err_d = 1'b1;
						end
					end
					PH_DEC: begin
						if (cls.dec_ok) begin
							cur_d = acc;
							err_d = sat;
						end else begin
							err_d = 1'b1;
						end
					end
					PH_ZERO: begin
						if (cls.is_x) begin
							phase_d = PH_HEXPFX;
						end else if (cls.oct_ok) begin
							cur_d   = acc;
							err_d   = sat;
							phase_d = PH_OCT;
						end else begin
							err_d = 1'b1;
						end
					end
					PH_OCT: begin
						if (cls.oct_ok) begin
							cur_d = acc;
							err_d = sat;
						end else begin
							err_d = 1'b1;
						end
					end
					PH_HEXPFX, PH_HEX: begin
						if (cls.hex_ok) begin
							cur_d   = acc;
							err_d   = sat;
							phase_d = PH_HEX;
						end else begin
							err_d = 1'b1;
						end
					end
					default: err_d = 1'b1;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			idx_q   <= '0;
			cur_q   <= '0;
			err_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			cur_q   <= cur_d;
			err_q   <= err_d;
		end
	end

	// finished parts, only read below the part index
	always_ff @(posedge clk) begin
		if (step && part_we) begin
			parts_q[idx_q] <= part_new;
		end
	end

endmodule

// ===== rtl/ipv4_dotted_address_parser.sv =====
// top level of the ipv4 dotted address parser
// usage:
//   the char channel (char_valid, char_stall, char_code) takes one byte of an
//   address string per item; a nul byte closes the string
//   the res channel (res_valid, res_stall, valid_res, address, part_count)
//   gives one item for each nul: the valid flag, the host-order address
//   (zero when invalid) and the number of dotted parts seen
//   a byte is taken every cycle while char_stall is low; each byte is held in the
//   input register, where the classifier and state update parse it
//   a nul's result is registered when the nul is parsed, and drives res_valid
//   throughput: one byte per cycle while char_stall is low, set by the parse step
//   while a result waits under res_stall, non-nul bytes are still taken and
//   parsed; only a second nul waits in the input register, and char_stall
//   rises behind it until the waiting result is taken
//   reset clears the parse state and both valid flags, so the first byte
//   after reset starts a fresh string
`timescale 1ns / 1ps
module ipv4_dotted_address_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          char_valid,
	output logic                          char_stall,
	input  logic [ipv4p_pkg::CharW-1:0]   char_code,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic                          valid_res,
	output logic [ipv4p_pkg::AddrW-1:0]   address,
	output logic [ipv4p_pkg::CountW-1:0]  part_count
);

	logic                          valid_s1;
	logic [ipv4p_pkg::CharW-1:0]   char_s1;
	ipv4p_pkg::char_class_t        cls;
	ipv4p_pkg::result_t            res;
	ipv4p_pkg::result_t            res_q;
	logic                          res_valid_q;
	logic                          step;
	logic                          res_load;

	ipv4p_char_class u_class (
		.char_code (char_s1),
		.cls       (cls)
	);

	ipv4p_parse_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cls    (cls),
		.res    (res)
	);

	always_comb begin
		step       = valid_s1 && !(cls.is_nul && res_valid_q && res_stall);
		res_load   = step && cls.is_nul;
		char_stall = valid_s1 && !step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!char_stall && char_valid) begin
			char_s1 <= char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign res_valid  = res_valid_q;
	assign valid_res  = res_q.valid_res;
	assign address    = res_q.address;
	assign part_count = res_q.part_count;

endmodule

// ===== rtl/ipv4p_checker.sv =====
// port checker for the ipv4 dotted address parser and its bind
`timescale 1ns / 1ps
module ipv4p_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          char_stall,
	input logic                          res_valid,
	input logic                          res_stall,
	input logic                          valid_res,
	input logic [ipv4p_pkg::AddrW-1:0]   address,
	input logic [ipv4p_pkg::CountW-1:0]  part_count
);

	// a stalled result item stays
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(valid_res)
			&& $stable(address) && $stable(part_count))
		else $error("result item changed under stall");

	// an invalid result carries a zero address
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !valid_res |-> address == '0)
		else $error("invalid result with non-zero address");

	// part count stays within one to four
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> part_count != 3'd0 && part_count <= 3'd4)
		else $error("part count out of range");

	// input is only held back while a result waits under stall
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> res_valid && res_stall)
		else $error("char stall without a waiting result");

	// no result straight after reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !res_valid)
		else $error("result valid after reset");

endmodule

bind ipv4_dotted_address_parser ipv4p_checker u_ipv4p_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.char_stall (char_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.valid_res  (valid_res),
	.address    (address),
	.part_count (part_count)
);

// ===== tb/tb_ipv4_dotted_address_parser.sv =====
// testbench for the ipv4 dotted address parser: byte streams in, parse model, result checks
`timescale 1ns / 1ps
module tb_ipv4_dotted_address_parser;

	localparam int unsigned RANDOM_BYTES  = 600;
	localparam int unsigned CALM_TAIL     = 100;
	localparam int unsigned QUIET_LIMIT   = 1000;
	localparam int unsigned SETTLE_CYCLES = 8;

	typedef enum logic [2:0] {
		SCAN_START,
		SCAN_DEC,
		SCAN_ZERO,
		SCAN_HEX_PREFIX,
		SCAN_OCT,
		SCAN_HEX,
		SCAN_DONE
	} scan_phase_t;

	typedef struct packed {
		logic                        wait_drain;
		logic [ipv4p_pkg::CharW-1:0] code;
	} queued_char_t;

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         char_valid = 1'b0;
	logic                         char_stall;
	logic [ipv4p_pkg::CharW-1:0]  char_code  = '0;
	logic                         res_valid;
	logic                         res_stall  = 1'b0;
	logic                         valid_res;
	logic [ipv4p_pkg::AddrW-1:0]  address;
	logic [ipv4p_pkg::CountW-1:0] part_count;

	queued_char_t       pending_chars[$];
	ipv4p_pkg::result_t expected_results[$];
	ipv4p_pkg::result_t want;
	logic               hold_for_drain = 1'b0;
	logic               char_taken     = 1'b0;

	int unsigned send_gap        = 0;
	int unsigned recv_gap        = 0;
	int unsigned bytes_sent      = 0;
	int unsigned strings_queued  = 0;
	int unsigned results_checked = 0;
	int unsigned good_addresses  = 0;
	int unsigned mismatches      = 0;
	int unsigned quiet_cycles    = 0;

	// parse model state
	scan_phase_t                 scan_phase;
	logic [1:0]                  part_idx;
	logic [ipv4p_pkg::PartW-1:0] done_parts [3];
	logic [ipv4p_pkg::ValW-1:0]  part_value;
	logic                        parse_err;

	always #5 clk = ~clk;

	ipv4_dotted_address_parser DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.valid_res  (valid_res),
		.address    (address),
		.part_count (part_count)
	);

	task automatic clear_parse();
		scan_phase    = SCAN_START;
		part_idx      = '0;
		done_parts[0] = '0;
		done_parts[1] = '0;
		done_parts[2] = '0;
		part_value    = '0;
		parse_err     = 1'b0;
	endtask

	task automatic accumulate(input int unsigned radix, input logic [3:0] digit);
		logic [39:0] sum;
		sum = {7'd0, part_value} * radix + digit;
		if (sum > 40'hffff_ffff) begin
			part_value = 33'h1_0000_0000;
			parse_err  = 1'b1;
		end else begin
			part_value = sum[ipv4p_pkg::ValW-1:0];
		end
	endtask

	task automatic predict_char(input logic [ipv4p_pkg::CharW-1:0] c);
		ipv4p_pkg::result_t          r;
		logic                        ws;
		logic                        whole_part;
		logic                        ok;
		logic                        hex_ok;
		logic [3:0]                  hex_d;
		logic [ipv4p_pkg::AddrW-1:0] last;
		logic [ipv4p_pkg::AddrW-1:0] addr;
		ws         = (c >= ipv4p_pkg::ChTab && c <= ipv4p_pkg::ChCr) || c == ipv4p_pkg::ChSp;
		whole_part = scan_phase != SCAN_START && scan_phase != SCAN_HEX_PREFIX &&
			scan_phase != SCAN_DONE;
		hex_ok     = 1'b1;
		hex_d      = '0;
		if (c >= ipv4p_pkg::ChD0 && c <= ipv4p_pkg::ChD9) begin
			hex_d = 4'(c - ipv4p_pkg::ChD0);
		end else if (c >= ipv4p_pkg::ChLa && c <= ipv4p_pkg::ChLf) begin
			hex_d = 4'(c - ipv4p_pkg::ChLa + 8'd10);
		end else if (c >= ipv4p_pkg::ChUa && c <= ipv4p_pkg::ChUf) begin
			hex_d = 4'(c - ipv4p_pkg::ChUa + 8'd10);
		end else begin
			hex_ok = 1'b0;
		end

		if (c == ipv4p_pkg::ChNul) begin
			ok   = !parse_err && (scan_phase == SCAN_DONE || whole_part);
			last = part_value[ipv4p_pkg::AddrW-1:0];
			addr = '0;
			case (part_idx)
				2'd0: addr = last;
				2'd1: begin
					if (last > 32'hff_ffff || done_parts[0] > 9'hff) ok = 1'b0;
					else addr = {done_parts[0][7:0], last[23:0]};
				end
				2'd2: begin
					if (last > 32'hffff || done_parts[0] > 9'hff || done_parts[1] > 9'hff)
						ok = 1'b0;
					else addr = {done_parts[0][7:0], done_parts[1][7:0], last[15:0]};
				end
				default: begin
					if (last > 32'hff || done_parts[0] > 9'hff || done_parts[1] > 9'hff ||
							done_parts[2] > 9'hff)
						ok = 1'b0;
					else addr = {done_parts[0][7:0], done_parts[1][7:0],
						done_parts[2][7:0], last[7:0]};
				end
			endcase
			r.valid_res  = ok;
			r.address    = ok ? addr : '0;
			r.part_count = {1'b0, part_idx} + 3'd1;
			expected_results = {expected_results, r};
			clear_parse();
		end else if (!parse_err && scan_phase != SCAN_DONE) begin
			if (c == ipv4p_pkg::ChDot || ws) begin
				if (!whole_part) begin
					parse_err = 1'b1;
				end else if (ws) begin
					scan_phase = SCAN_DONE;
				end else if (part_idx == 2'd3) begin
					parse_err = 1'b1;
				end else begin
					done_parts[part_idx] = part_value > 33'hff ? 9'h100 :
						part_value[ipv4p_pkg::PartW-1:0];
					part_idx   = part_idx + 2'd1;
					part_value = '0;
					scan_phase = SCAN_START;
				end
			end else begin
				case (scan_phase)
					SCAN_START: begin
						if (c == ipv4p_pkg::ChD0) begin
							scan_phase = SCAN_ZERO;
						end else if (c > ipv4p_pkg::ChD0 && c <= ipv4p_pkg::ChD9) begin
							part_value = {29'd0, hex_d};
							scan_phase = SCAN_DEC;
						end else begin
							parse_err = 1'b1;
						end
					end
					SCAN_DEC: begin
						if (c >= ipv4p_pkg::ChD0 && c <= ipv4p_pkg::ChD9) accumulate(10, hex_d);
						else parse_err = 1'b1;
					end
					SCAN_ZERO: begin
						if (c == ipv4p_pkg::ChLx || c == ipv4p_pkg::ChUx) begin
							scan_phase = SCAN_HEX_PREFIX;
						end else if (c >= ipv4p_pkg::ChD0 && c <= ipv4p_pkg::ChD7) begin
							accumulate(8, hex_d);
							scan_phase = SCAN_OCT;
						end else begin
							parse_err = 1'b1;
						end
					end
					SCAN_OCT: begin
						if (c >= ipv4p_pkg::ChD0 && c <= ipv4p_pkg::ChD7) accumulate(8, hex_d);
						else parse_err = 1'b1;
					end
					SCAN_HEX_PREFIX, SCAN_HEX: begin
						if (hex_ok) begin
							accumulate(16, hex_d);
							scan_phase = SCAN_HEX;
						end else begin
							parse_err = 1'b1;
						end
					end
					default: parse_err = 1'b1;
				endcase
			end
		end
	endtask

	function automatic int unsigned idle_chance(input int unsigned stage);
		case (stage % 3)
			0:       return 0;
			1:       return 12;
			default: return 40;
		endcase
	endfunction

	task automatic push_char(input logic [ipv4p_pkg::CharW-1:0] c);
		queued_char_t q;
		q.wait_drain   = hold_for_drain;
		q.code         = c;
		hold_for_drain = 1'b0;
		pending_chars  = {pending_chars, q};
	endtask

	task automatic queue_text(input string s);
		for (int k = 0; k < s.len(); k++)
			push_char(s[k]);
		push_char(ipv4p_pkg::ChNul);
		strings_queued++;
	endtask

	// mostly well-formed addresses with random radix and values, some corrupted or noise
	task automatic queue_random_address();
		int unsigned nparts;
		int unsigned mode;
		int unsigned kind;
		int unsigned bad_at;
		logic [32:0] lim;
		logic [32:0] v;
		string       txt;
		string       part;
		hold_for_drain = ($urandom_range(14) == 0) || hold_for_drain;
		kind = $urandom_range(9);
		if (kind == 0) begin
			repeat ($urandom_range(8, 1)) push_char(8'($urandom_range(255, 1)));
		end else begin
			nparts = $urandom_range(4, 1);
			if ($urandom_range(19) == 0) nparts = 5;
			txt = "";
			for (int i = 0; i < nparts; i++) begin
				if (i < nparts - 1) begin
					lim = 33'hff;
				end else begin
					case (nparts)
						1:       lim = 33'hffff_ffff;
						2:       lim = 33'hff_ffff;
						3:       lim = 33'hffff;
						default: lim = 33'hff;
					endcase
				end
				mode = $urandom_range(9);
				case (mode)
					0:       v = '0;
					1:       v = lim;
					2:       v = lim + 33'd1;
					3:       v = 33'($urandom_range(255));
					default: v = {1'b0, $urandom} & lim;
				endcase
				if (v > 33'hffff_ffff) begin
					part = {"0x1", $sformatf("%08h", v[31:0])};
				end else begin
					case ($urandom_range(2))
						0: part = $sformatf("%0d", v[31:0]);
						1: part = (v == 0) ? "0" : {"0", $sformatf("%0o", v[31:0])};
						default: begin
							part = {"0x", $sformatf("%0h", v[31:0])};
							if ($urandom_range(1)) part = part.toupper();
						end
					endcase
				end
				txt = (i == 0) ? part : {txt, ".", part};
			end
			if (kind == 2) txt = {txt, "."};
			bad_at = (kind == 1) ? $urandom_range(txt.len() - 1) : txt.len();
			for (int k = 0; k < txt.len(); k++)
				push_char(k == bad_at ? 8'($urandom_range(255, 1)) : txt[k]);
			if ($urandom_range(3) == 0) begin
				mode = $urandom_range(5);
				push_char(mode == 5 ? ipv4p_pkg::ChSp : 8'(ipv4p_pkg::ChTab + mode));
				repeat ($urandom_range(4)) push_char(8'($urandom_range(255, 1)));
			end
		end
		push_char(ipv4p_pkg::ChNul);
		strings_queued++;
	endtask

	// char channel: acceptance and prediction
	always @(posedge clk) begin
		if (arst_n) begin
			char_taken <= char_valid && !char_stall;
			if (char_valid && !char_stall) begin
				predict_char(char_code);
				void'(pending_chars.pop_front());
				bytes_sent++;
			end
		end
	end

	// char channel: driver
	always @(negedge clk) begin
		if (arst_n && !(char_valid && !char_taken)) begin
			if (send_gap != 0) begin
				char_valid <= 1'b0;
				send_gap   <= send_gap - 1;
			end else if (pending_chars.size() == 0 ||
					(pending_chars[0].wait_drain && expected_results.size() != 0)) begin
				char_valid <= 1'b0;
			end else if (pending_chars.size() > CALM_TAIL &&
					$urandom_range(99) < idle_chance(bytes_sent / 97)) begin
				char_valid <= 1'b0;
				send_gap   <= $urandom_range(14);
			end else begin
				char_valid <= 1'b1;
				char_code  <= pending_chars[0].code;
			end
		end
	end

	// result channel: stall pattern
	always @(negedge clk) begin
		if (recv_gap != 0) begin
			res_stall <= 1'b1;
			recv_gap  <= recv_gap - 1;
		end else if (pending_chars.size() > CALM_TAIL &&
				$urandom_range(99) < idle_chance(results_checked / 5 + 1)) begin
			res_stall <= 1'b1;
			recv_gap  <= $urandom_range(14);
		end else begin
			res_stall <= 1'b0;
		end
	end

	// result channel: checker
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				$error("result item with none expected: valid_res %0d address %h part_count %0d",
					valid_res, address, part_count);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (valid_res !== want.valid_res) begin
					$error("valid_res expected %0d got %0d", want.valid_res, valid_res);
					mismatches++;
				end
				if (address !== want.address) begin
					$error("address expected %h got %h", want.address, address);
					mismatches++;
				end
				if (part_count !== want.part_count) begin
					$error("part_count expected %0d got %0d", want.part_count, part_count);
					mismatches++;
				end
				results_checked++;
				if (want.valid_res) good_addresses++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((char_valid && !char_stall) || (res_valid && !res_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned random_start;
		clear_parse();

		// forms, radices, extremes and error paths
		queue_text("");
		queue_text("0");
		queue_text("4294967295");
		queue_text("4294967296");
		queue_text("0xFFFFFFFF");
		queue_text("0x100000000");
		queue_text("037777777777");
		queue_text("0.0.0.0");
		queue_text("255.255.255.255");
		queue_text("256.1.2.3");
		queue_text("1.16777215");
		queue_text("1.0x1000000");
		queue_text("1.2.65535");
		queue_text("1.2.3.256");
		queue_text("1.2.3.4.5");
		queue_text("1..2");
		queue_text(".1");
		queue_text("1.");
		queue_text("0x");
		queue_text("08");
		queue_text("07x");
		queue_text("0xAbCg");
		queue_text(" 1");
		for (int w = 0; w < 6; w++) begin
			push_char(ipv4p_pkg::ChD7);
			push_char(w == 5 ? ipv4p_pkg::ChSp : 8'(ipv4p_pkg::ChTab + w));
			push_char(ipv4p_pkg::ChLx);
			push_char(ipv4p_pkg::ChNul);
			strings_queued++;
		end

		// random part starts from an empty pipeline
		hold_for_drain = 1'b1;
		random_start   = pending_chars.size();
		while (pending_chars.size() - random_start < RANDOM_BYTES)
			queue_random_address();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_chars.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("sent %0d bytes in %0d strings: all four forms, three radices, error cases",
			bytes_sent, strings_queued);
		$display("checked %0d results: %0d good addresses, %0d rejected, %0d mismatches",
			results_checked, good_addresses, results_checked - good_addresses, mismatches);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ipv4p_pkg.sv
rtl/ipv4p_char_class.sv
rtl/ipv4p_parse_core.sv
rtl/ipv4_dotted_address_parser.sv
rtl/ipv4p_checker.sv
tb/tb_ipv4_dotted_address_parser.sv
